// ----- rtl/c_string_escape_decoder_top_macros.svh -----
// ----------------------------------------------------------------------------
// C string escape decoder assertion macros
// Concurrent assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef C_STRING_ESCAPE_DECODER_TOP_MACROS_SVH
`define C_STRING_ESCAPE_DECODER_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define CSED_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("c_string_escape_decoder check failed");

// next-cycle implication, disabled during reset
`define CSED_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("c_string_escape_decoder check failed");

`endif

// ----- rtl/csed_pkg.sv -----
// ----------------------------------------------------------------------------
// C string escape decoder package
// Item types, state codes, character constants and decode helpers.
// ----------------------------------------------------------------------------
package csed_pkg;

	typedef struct packed {
		logic [7:0] char_in;
		logic       end_of_string;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_byte;
		logic       bad_escape;
	} out_item_t;

	typedef enum logic [3:0] {
		MODE_PLAIN = 4'b0001,
		MODE_BSL   = 4'b0010,
		MODE_HEX   = 4'b0100,
		MODE_OCT   = 4'b1000
	} mode_t;

	localparam logic [7:0]  CH_BACKSLASH = 8'h5C;
	localparam logic [7:0]  CH_X         = 8'h78;
	localparam logic [7:0]  CH_ZERO      = 8'h30;
	localparam logic [15:0] MAX_RESET    = 16'hFFFF;

	localparam int unsigned RES_DEPTH = 4;
	localparam int unsigned PTR_W     = $clog2(RES_DEPTH);
	localparam int unsigned CNT_W     = $clog2(RES_DEPTH + 1);

	// {valid, digit value}
	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
		else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
		else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
		return r;
	endfunction

	// {valid, byte value}
	function automatic logic [8:0] simple_decode(input logic [7:0] c);
		logic [8:0] r;
		r = 9'd0;
		unique case (c)
			8'h6E: r = {1'b1, 8'h0A};
			8'h74: r = {1'b1, 8'h09};
			8'h72: r = {1'b1, 8'h0D};
			8'h61: r = {1'b1, 8'h07};
			8'h62: r = {1'b1, 8'h08};
			8'h66: r = {1'b1, 8'h0C};
			8'h76: r = {1'b1, 8'h0B};
			8'h5C: r = {1'b1, 8'h5C};
			8'h27: r = {1'b1, 8'h27};
			8'h22: r = {1'b1, 8'h22};
			8'h3F: r = {1'b1, 8'h3F};
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

// ----- rtl/c_string_escape_decoder_top.sv -----
// ----------------------------------------------------------------------------
// C string escape decoder
// Decodes the body of a C string literal into bytes, one character per item.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_stall carries in_data: one raw character and an
// end_of_string mark on the final character of the literal body.
// Output channel out_valid/out_stall carries out_data: a decoded byte, its
// last_byte mark and a bad_escape flag. One character yields zero, one or two
// bytes. The cfg_valid/cfg_ready channel writes the per-string byte limit;
// cfg_ready is always high; writes must go in while the block is idle, which
// the block itself does not enforce. An accepted character is held in the
// input register and its decoded bytes are written to the result queue, which
// drives out_valid. One character is taken every cycle while the queue has
// room; the rate is set by the four-entry result queue, which needs room for
// two bytes before the input register hands its character to the decode logic.
// Reset clears the decode state, the byte count and the queue, and sets the
// limit to 65535. When the receiver stalls, the queue fills and in_stall
// rises; nothing is lost or repeated.
module c_string_escape_decoder_top
	import csed_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data,
	input  logic      cfg_valid,
	output logic      cfg_ready,
	input  logic [15:0] cfg_data
);

	logic             item_valid_s1;
	in_item_t         item_s1;
	mode_t            mode_q;
	logic [7:0]       acc_q;
	logic [1:0]       dig_q;
	logic [15:0]      cnt_q;
	logic [15:0]      max_q;

	out_item_t        res_mem [RES_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] fill_q;

	mode_t            nxt_mode;
	logic [7:0]       nxt_acc;
	logic [1:0]       nxt_dig;
	logic [15:0]      nxt_cnt;
	logic [2:0]       cand_v;
	logic [7:0]       cand_byte [3];
	logic [2:0]       cand_bad;
	out_item_t        res [2];
	logic [1:0]       n_res;
	logic [4:0]       hx;
	logic [8:0]       se;
	logic [7:0]       ch;
	logic             adv;
	logic             pop;

	assign cfg_ready = 1'b1;
	assign adv       = item_valid_s1 && (fill_q <= CNT_W'(RES_DEPTH - 2));
	assign in_stall  = item_valid_s1 && !adv;
	assign pop       = out_valid && !out_stall;
	assign out_valid = (fill_q != '0);
	assign out_data  = res_mem[rd_ptr_q];
	assign ch        = item_s1.char_in;

	always_comb begin
		nxt_mode  = mode_q;
		nxt_acc   = acc_q;
		nxt_dig   = dig_q;
		cand_v    = '0;
		cand_bad  = '0;
		cand_byte[0] = ch;
		cand_byte[1] = ch;
		cand_byte[2] = 8'h00;
		hx = hex_decode(ch);
		se = simple_decode(ch);
		unique case (mode_q)
			MODE_PLAIN: begin
				if (ch == CH_BACKSLASH) nxt_mode = MODE_BSL;
				else cand_v[0] = 1'b1;
			end
			MODE_BSL: begin
				nxt_mode = MODE_PLAIN;
				nxt_acc  = 8'h00;
				nxt_dig  = 2'd0;
				if (ch == CH_X) begin
					nxt_mode = MODE_HEX;
				end else if (ch[7:2] == CH_ZERO[7:2]) begin
					nxt_mode = MODE_OCT;
					nxt_acc  = {6'd0, ch[1:0]};
					nxt_dig  = 2'd1;
				end else if (se[8]) begin
					cand_v[0]    = 1'b1;
					cand_byte[0] = se[7:0];
				end else begin
					cand_v[0]   = 1'b1;
					cand_bad[0] = 1'b1;
				end
			end
			MODE_HEX: begin
				if (hx[4]) begin
					nxt_acc = {acc_q[3:0], hx[3:0]};
					nxt_dig = dig_q + 2'd1;
					if (dig_q != 2'd0) begin
						cand_v[0]    = 1'b1;
						cand_byte[0] = nxt_acc;
						nxt_mode     = MODE_PLAIN;
						nxt_acc      = 8'h00;
						nxt_dig      = 2'd0;
					end
				end else begin
					cand_v[0]    = 1'b1;
					cand_byte[0] = (dig_q == 2'd0) ? 8'h00 : acc_q;
					cand_bad[0]  = (dig_q == 2'd0);
					nxt_mode     = MODE_PLAIN;
					nxt_acc      = 8'h00;
					nxt_dig      = 2'd0;
					if (ch == CH_BACKSLASH) nxt_mode = MODE_BSL;
					else cand_v[1] = 1'b1;
				end
			end
			MODE_OCT: begin
				if (ch[7:3] == CH_ZERO[7:3]) begin
					nxt_acc = {acc_q[4:0], ch[2:0]};
					nxt_dig = dig_q + 2'd1;
					if (dig_q == 2'd2) begin
						cand_v[0]    = 1'b1;
						cand_byte[0] = nxt_acc;
						nxt_mode     = MODE_PLAIN;
						nxt_acc      = 8'h00;
						nxt_dig      = 2'd0;
					end
				end else begin
					cand_v[0]    = 1'b1;
					cand_byte[0] = acc_q;
					nxt_mode     = MODE_PLAIN;
					nxt_acc      = 8'h00;
					nxt_dig      = 2'd0;
					if (ch == CH_BACKSLASH) nxt_mode = MODE_BSL;
					else cand_v[1] = 1'b1;
				end
			end
			default: begin
				nxt_mode = MODE_PLAIN;
				nxt_acc  = 8'h00;
				nxt_dig  = 2'd0;
			end
		endcase

		if (item_s1.end_of_string) begin
			priority case (1'b1)
				nxt_mode == MODE_BSL: begin
					cand_v[2]    = 1'b1;
					cand_byte[2] = CH_BACKSLASH;
					cand_bad[2]  = 1'b1;
				end
				nxt_mode == MODE_HEX: begin
					cand_v[2]    = 1'b1;
					cand_byte[2] = (nxt_dig == 2'd0) ? 8'h00 : nxt_acc;
					cand_bad[2]  = (nxt_dig == 2'd0);
				end
				nxt_mode == MODE_OCT: begin
					cand_v[2]    = 1'b1;
					cand_byte[2] = nxt_acc;
				end
				default: cand_v[2] = 1'b0;
			endcase
			nxt_mode = MODE_PLAIN;
			nxt_acc  = 8'h00;
			nxt_dig  = 2'd0;
		end
	end

	always_comb begin
		n_res  = 2'd0;
		res[0] = '0;
		res[1] = '0;
		for (int k = 0; k < 3; k++) begin
			if (cand_v[k] && (n_res != 2'd2) &&
			    (({1'b0, cnt_q} + 17'(n_res)) < {1'b0, max_q})) begin
				res[n_res[0]].out_byte   = cand_byte[k];
				res[n_res[0]].bad_escape = cand_bad[k];
				n_res = n_res + 2'd1;
			end
		end
		if (item_s1.end_of_string) begin
			if (n_res == 2'd2) res[1].last_byte = 1'b1;
			else if (n_res == 2'd1) res[0].last_byte = 1'b1;
		end
		nxt_cnt = item_s1.end_of_string ? 16'd0 : cnt_q + 16'(n_res);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			item_valid_s1 <= 1'b1;
		end else if (adv) begin
			item_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_PLAIN;
			acc_q  <= 8'h00;
			dig_q  <= 2'd0;
			cnt_q  <= 16'd0;
		end else if (adv) begin
			mode_q <= nxt_mode;
			acc_q  <= nxt_acc;
			dig_q  <= nxt_dig;
			cnt_q  <= nxt_cnt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= MAX_RESET;
		end else if (cfg_valid && cfg_ready) begin
			max_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && (n_res != 2'd0)) begin
			res_mem[wr_ptr_q] <= res[0];
		end
		if (adv && (n_res == 2'd2)) begin
			res_mem[wr_ptr_q + PTR_W'(1)] <= res[1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (adv) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(n_res);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			fill_q <= fill_q + (adv ? CNT_W'(n_res) : CNT_W'(0)) - CNT_W'(pop);
		end
	end

endmodule

// ----- rtl/csed_checker.sv -----
// ----------------------------------------------------------------------------
// C string escape decoder port checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "c_string_escape_decoder_top_macros.svh"

module csed_checker
	import csed_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_stall,
	input in_item_t  in_data,
	input logic      out_valid,
	input logic      out_stall,
	input out_item_t out_data,
	input logic      cfg_valid,
	input logic      cfg_ready
);

	`CSED_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid)
	`CSED_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && out_stall, $stable(out_data))
	`CSED_ASSERT_NEXT(a_in_hold, clk, arst_n, in_valid && in_stall, in_valid && $stable(in_data))
	`CSED_ASSERT_IMPL(a_stall_backed, clk, arst_n, in_stall, out_valid)
	`CSED_ASSERT_IMPL(a_cfg_open, clk, arst_n, cfg_valid, cfg_ready)

endmodule

bind c_string_escape_decoder_top csed_checker u_csed_checker (.*);

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// C string escape decoder testbench
// Feeds literal bodies one character per item, with directed escape cases
// followed by random strings under several byte limits and idle patterns.
// An in-bench decoder predicts every byte, and each output item is checked
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
	import csed_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE_CYCLES = 12;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	in_item_t    in_data = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	out_item_t   out_data;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data = '0;

	c_string_escape_decoder_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	int cycles = 0;
	int errors = 0;
	int chars_sent = 0;
	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;

	// decoder shadow state
	logic [15:0] byte_limit = MAX_RESET;
	mode_t       dec_mode = MODE_PLAIN;
	logic [7:0]  esc_acc = '0;
	logic [1:0]  esc_digits = '0;
	logic [15:0] bytes_out = '0;

	out_item_t   step_bytes[$];
	out_item_t   expected_bytes[$];
	logic [7:0]  text_q[$];

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	always @(negedge clk)
		out_stall <= (receiver_stall_pct > 0) && ($urandom_range(99) < receiver_stall_pct);

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_bytes.size() == 0) begin
				$display("%0t: unexpected byte, expected none actual %02h/%0b/%0b", $time,
					out_data.out_byte, out_data.last_byte, out_data.bad_escape);
				errors++;
			end else begin
				want = expected_bytes.pop_front();
				if (out_data.out_byte !== want.out_byte) begin
					$display("%0t: out_byte expected %02h actual %02h", $time,
						want.out_byte, out_data.out_byte);
					errors++;
				end
				if (out_data.last_byte !== want.last_byte) begin
					$display("%0t: last_byte expected %0b actual %0b", $time,
						want.last_byte, out_data.last_byte);
					errors++;
				end
				if (out_data.bad_escape !== want.bad_escape) begin
					$display("%0t: bad_escape expected %0b actual %0b", $time,
						want.bad_escape, out_data.bad_escape);
					errors++;
				end
			end
		end
	end

	function automatic int hex_digit(input logic [7:0] c);
		if (c >= "0" && c <= "9") return int'(c - "0");
		if (c >= "a" && c <= "f") return int'(c - "a") + 10;
		if (c >= "A" && c <= "F") return int'(c - "A") + 10;
		return -1;
	endfunction

	function automatic int escape_code(input logic [7:0] c);
		case (c)
			"n": return 'h0A;
			"t": return 'h09;
			"r": return 'h0D;
			"a": return 'h07;
			"b": return 'h08;
			"f": return 'h0C;
			"v": return 'h0B;
			"\\": return 'h5C;
			"'": return 'h27;
			"\"": return 'h22;
			"?": return 'h3F;
			default: return -1;
		endcase
	endfunction

	function automatic void put_byte(input logic [7:0] value, input logic bad);
		out_item_t r;
		if (bytes_out >= byte_limit || step_bytes.size() >= 2) return;
		r.out_byte = value;
		r.last_byte = 1'b0;
		r.bad_escape = bad;
		step_bytes.push_back(r);
		bytes_out++;
	endfunction

	function automatic void flush_escape();
		case (dec_mode)
			MODE_BSL: put_byte(CH_BACKSLASH, 1'b1);
			MODE_HEX: begin
				if (esc_digits == 0) put_byte(8'h00, 1'b1);
				else put_byte(esc_acc, 1'b0);
			end
			MODE_OCT: put_byte(esc_acc, 1'b0);
			default: ;
		endcase
		dec_mode = MODE_PLAIN;
		esc_acc = '0;
		esc_digits = '0;
	endfunction

	function automatic void take_plain(input logic [7:0] c);
		if (c == CH_BACKSLASH) dec_mode = MODE_BSL;
		else put_byte(c, 1'b0);
	endfunction

	function automatic void decode_char(input in_item_t it);
		logic [7:0] c;
		int v;
		c = it.char_in;
		step_bytes.delete();
		case (dec_mode)
			MODE_PLAIN: take_plain(c);
			MODE_BSL: begin
				dec_mode = MODE_PLAIN;
				esc_acc = '0;
				esc_digits = '0;
				if (c == CH_X) begin
					dec_mode = MODE_HEX;
				end else if (c >= CH_ZERO && c < "4") begin
					dec_mode = MODE_OCT;
					esc_acc = c - CH_ZERO;
					esc_digits = 2'd1;
				end else begin
					v = escape_code(c);
					if (v >= 0) put_byte(v[7:0], 1'b0);
					else put_byte(c, 1'b1);
				end
			end
			MODE_HEX: begin
				v = hex_digit(c);
				if (v >= 0) begin
					esc_acc = {esc_acc[3:0], v[3:0]};
					esc_digits++;
					if (esc_digits >= 2) flush_escape();
				end else begin
					flush_escape();
					take_plain(c);
				end
			end
			default: begin
				if (c >= "0" && c <= "7") begin
					esc_acc = {esc_acc[4:0], c[2:0]};
					esc_digits++;
					if (esc_digits >= 3) flush_escape();
				end else begin
					flush_escape();
					take_plain(c);
				end
			end
		endcase
		if (it.end_of_string) begin
			flush_escape();
			if (step_bytes.size() > 0) step_bytes[$].last_byte = 1'b1;
			bytes_out = '0;
		end
		foreach (step_bytes[i]) expected_bytes.push_back(step_bytes[i]);
	endfunction

	task automatic send_char(input logic [7:0] c, input logic eos);
		in_item_t it;
		it.char_in = c;
		it.end_of_string = eos;
		@(negedge clk);
		if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			do @(negedge clk); while ($urandom_range(99) < sender_idle_pct);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (in_stall);
		decode_char(it);
		chars_sent++;
	endtask

	task automatic send_text(input bit terminate);
		foreach (text_q[i]) send_char(text_q[i], terminate && (i == text_q.size() - 1));
	endtask

	task automatic load_text(input string s);
		text_q.delete();
		for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_bytes.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_limit(input logic [15:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		byte_limit = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [7:0] plain_char();
		logic [7:0] c;
		do c = 8'($urandom_range(255)); while (c == CH_BACKSLASH);
		return c;
	endfunction

	function automatic void add_token();
		string hex_set;
		string esc_set;
		int kind;
		hex_set = "0123456789abcdefABCDEF";
		esc_set = "ntrabfv\\'\"?";
		kind = $urandom_range(99);
		if (kind < 35) begin
			text_q.push_back(plain_char());
		end else if (kind < 50) begin
			text_q.push_back(CH_BACKSLASH);
			text_q.push_back(esc_set[$urandom_range(10)]);
		end else if (kind < 65) begin
			text_q.push_back(CH_BACKSLASH);
			text_q.push_back(CH_X);
			repeat ($urandom_range(2)) text_q.push_back(hex_set[$urandom_range(21)]);
		end else if (kind < 80) begin
			text_q.push_back(CH_BACKSLASH);
			text_q.push_back(CH_ZERO + 8'($urandom_range(3)));
			repeat ($urandom_range(2)) text_q.push_back(CH_ZERO + 8'($urandom_range(7)));
		end else if (kind < 90) begin
			text_q.push_back(CH_BACKSLASH);
			text_q.push_back(8'($urandom_range(255)));
		end else begin
			text_q.push_back(8'($urandom_range(255)));
		end
	endfunction

	function automatic void build_random_string();
		text_q.delete();
		repeat ($urandom_range(1, 8)) add_token();
		// end some strings inside an escape
		case ($urandom_range(9))
			0: text_q.push_back(CH_BACKSLASH);
			1: begin
				text_q.push_back(CH_BACKSLASH);
				text_q.push_back(CH_X);
			end
			default: ;
		endcase
	endfunction

	task automatic test_plain_text();
		text_q.delete();
		text_q.push_back(8'h00);
		text_q.push_back(8'hFF);
		send_text(1'b1);
	endtask

	task automatic test_simple_escapes();
		load_text("\\n\\\\\\q");
		send_text(1'b1);
	endtask

	task automatic test_hex_escapes();
		load_text("\\xA5\\xg");
		send_text(1'b0);
		load_text("\\x4");
		send_text(1'b1);
	endtask

	task automatic test_octal_escapes();
		load_text("\\377\\18");
		send_text(1'b0);
	endtask

	task automatic test_lone_backslash();
		load_text("\\");
		send_text(1'b1);
	endtask

	task automatic test_zero_limit();
		int start;
		drain();
		write_limit(16'h0000);
		start = chars_sent;
		while (chars_sent - start < 30) begin
			build_random_string();
			send_text(1'b1);
		end
		drain();
	endtask

	task automatic test_random_strings(input int idle_pct, input int stall_pct,
		input logic [15:0] limit, input int n_chars, input bit hold_mid);
		int start;
		bit held;
		held = 1'b0;
		drain();
		write_limit(limit);
		sender_idle_pct = idle_pct;
		receiver_stall_pct = stall_pct;
		start = chars_sent;
		while (chars_sent - start < n_chars) begin
			build_random_string();
			send_text(1'b1);
			// hold until the output side is empty
			if (hold_mid && !held && (chars_sent - start > n_chars / 2)) begin
				drain();
				held = 1'b1;
			end
		end
		drain();
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
	endtask

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_plain_text();
		test_simple_escapes();
		test_hex_escapes();
		test_octal_escapes();
		test_lone_backslash();
		test_zero_limit();
		test_random_strings(0, 0, 16'hFFFF, 310, 1'b0);
		test_random_strings(84, 0, 16'($urandom_range(1, 6)), 310, 1'b1);
		test_random_strings(0, 84, 16'hFFFF, 310, 1'b0);
		test_random_strings(24, 24, 16'($urandom_range(2, 20)), 310, 1'b0);

		drain();
		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
